@@ sv/vna_pkg.sv @@
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types and fixed widths of the vertex normal accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

    localparam int COORD_BITS = 16;
    localparam int EDGE_BITS  = COORD_BITS + 1;
    localparam int NRM_BITS   = 2 * EDGE_BITS + 1;
    localparam int MUL_W      = 31;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int MAG_W      = 30;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    typedef struct packed {
        logic [1:0]             action;
        logic [7:0]             vertex_index;
        logic signed [15:0]     coord_x;
        logic signed [15:0]     coord_y;
        logic signed [15:0]     coord_z;
        logic [7:0]             corner_b;
        logic [7:0]             corner_c;
    } item_t;

    typedef struct packed {
        logic signed [15:0]     normal_x;
        logic signed [15:0]     normal_y;
        logic signed [15:0]     normal_z;
        logic                   zero_length;
    } result_t;

endpackage

@@ sv/vna_mul.sv @@
// ----------------------------------------------------------------------------
// vna_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module vna_mul
    import vna_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MUL_W-1:0]  op_a,
    input  logic signed [MUL_W-1:0]  op_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

@@ sv/vertex_normal_accumulator.sv @@
// ----------------------------------------------------------------------------
// vertex_normal_accumulator
// Area-weighted vertex normals of an indexed triangle mesh, fixed point.
// ----------------------------------------------------------------------------
// steps: write vertex and clear are done in the idle state; add triangle makes three vertex
//   reads, six products on the shared multiplier, three accumulator read-modify-writes
// read normal: a zero accumulator goes straight to the output, else the one-bit
//   normalizing shift, the 32-step square root and a bit-serial divide per component
// throughput: one transaction at a time, plus any wait for a stalled earlier result
// reset: asynchronous, then a clearing pass over all MAX_VERTICES accumulators
module vertex_normal_accumulator
    import vna_pkg::*;
#(
    parameter int MAX_VERTICES = 256,
    parameter int ACCUM_BITS   = 48
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int AB = ACCUM_BITS;
    localparam int VW = 3 * COORD_BITS;

    // sequencer states
    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_RDA   = 5'd2;
    localparam logic [4:0] S_RDB   = 5'd3;
    localparam logic [4:0] S_RDC   = 5'd4;
    localparam logic [4:0] S_EDGE  = 5'd5;
    localparam logic [4:0] S_CROSS = 5'd6;
    localparam logic [4:0] S_ARD   = 5'd7;
    localparam logic [4:0] S_AWR   = 5'd8;
    localparam logic [4:0] S_NRD   = 5'd9;
    localparam logic [4:0] S_NMAG  = 5'd10;
    localparam logic [4:0] S_NORM  = 5'd11;
    localparam logic [4:0] S_SQ    = 5'd12;
    localparam logic [4:0] S_SQRT  = 5'd13;
    localparam logic [4:0] S_DIVI  = 5'd14;
    localparam logic [4:0] S_DIV   = 5'd15;
    localparam logic [4:0] S_OUT   = 5'd16;

    // control registers
    logic [4:0]    state_reg, state_next;
    logic [4:0]    step_reg, step_next;
    logic [1:0]    cr_reg, cr_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          rv_reg, rv_next;

    // payload registers
    item_t                   cmd_reg, cmd_next;
    logic signed [COORD_BITS-1:0] ax_reg, ay_reg, az_reg, ax_next, ay_next, az_next;
    logic signed [EDGE_BITS-1:0]  ux_reg, uy_reg, uz_reg, ux_next, uy_next, uz_next;
    logic signed [EDGE_BITS-1:0]  vx_reg, vy_reg, vz_reg, vx_next, vy_next, vz_next;
    logic signed [NRM_BITS-1:0]   tmp_reg, tmp_next;
    logic signed [NRM_BITS-1:0]   nx_reg, ny_reg, nz_reg, nx_next, ny_next, nz_next;
    logic [AB-1:0]  mx_reg, my_reg, mz_reg, mm_reg, mx_next, my_next, mz_next, mm_next;
    logic [2:0]     sgn_reg, sgn_next;
    logic [PROD_W-1:0] sq_reg, sq_next;
    logic [62:0]    rs_reg, rr_reg, rb_reg, rs_next, rr_next, rb_next;
    logic [47:0]    rem_reg, dv_reg, rem_next, dv_next;
    logic [16:0]    q_reg, q_next;
    result_t        res_reg, res_next;
    result_t        out_reg, out_next;

    // memories
    logic [VW-1:0]   vmem [MAX_VERTICES];
    logic [3*AB-1:0] amem [MAX_VERTICES];
    logic [VW-1:0]   vrd_reg;
    logic [3*AB-1:0] ard_reg;
    logic            vwe, awe;
    logic [AW-1:0]   vaddr, araddr, awaddr;
    logic [3*AB-1:0] awdata;

    // shared multiplier
    logic signed [MUL_W-1:0]  op_a, op_b;
    logic signed [PROD_W-1:0] prod;

    vna_mul u_mul (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // item decode
    logic item_fire, out_fire;
    logic a_ok, b_ok, c_ok;
    logic [AW-1:0] adr_a, adr_b, adr_c, adr_corner;

    assign item_stall = (state_reg != S_IDLE);
    assign item_fire  = item_valid && !item_stall;
    assign out_fire   = rv_reg && !result_stall;
    assign a_ok = (32'(item.vertex_index) < MAX_VERTICES);
    assign b_ok = (32'(item.corner_b) < MAX_VERTICES);
    assign c_ok = (32'(item.corner_c) < MAX_VERTICES);
    assign adr_a = AW'(cmd_reg.vertex_index);
    assign adr_b = AW'(cmd_reg.corner_b);
    assign adr_c = AW'(cmd_reg.corner_c);
    assign adr_corner = (cr_reg == 2'd0) ? adr_a : ((cr_reg == 2'd1) ? adr_b : adr_c);

    // vertex read data split
    logic signed [COORD_BITS-1:0] rdx, rdy, rdz;
    assign rdx = vrd_reg[3*COORD_BITS-1:2*COORD_BITS];
    assign rdy = vrd_reg[2*COORD_BITS-1:COORD_BITS];
    assign rdz = vrd_reg[COORD_BITS-1:0];

    // accumulator read data split and saturating add of the face normal
    logic signed [AB-1:0] acx, acy, acz;
    logic signed [AB:0]   sumx, sumy, sumz;
    logic signed [AB-1:0] satx, saty, satz;
    localparam logic signed [AB-1:0] ACC_HI = {1'b0, {(AB-1){1'b1}}};
    localparam logic signed [AB-1:0] ACC_LO = {1'b1, {(AB-1){1'b0}}};

    assign acx = ard_reg[3*AB-1:2*AB];
    assign acy = ard_reg[2*AB-1:AB];
    assign acz = ard_reg[AB-1:0];
    assign sumx = (AB+1)'(acx) + (AB+1)'(nx_reg);
    assign sumy = (AB+1)'(acy) + (AB+1)'(ny_reg);
    assign sumz = (AB+1)'(acz) + (AB+1)'(nz_reg);
    assign satx = (sumx[AB] != sumx[AB-1]) ? (sumx[AB] ? ACC_LO : ACC_HI) : sumx[AB-1:0];
    assign saty = (sumy[AB] != sumy[AB-1]) ? (sumy[AB] ? ACC_LO : ACC_HI) : sumy[AB-1:0];
    assign satz = (sumz[AB] != sumz[AB-1]) ? (sumz[AB] ? ACC_LO : ACC_HI) : sumz[AB-1:0];

    // magnitudes of the read accumulator
    logic [AB-1:0] magx, magy, magz, magxy, magm;
    assign magx  = acx[AB-1] ? AB'(-acx) : AB'(acx);
    assign magy  = acy[AB-1] ? AB'(-acy) : AB'(acy);
    assign magz  = acz[AB-1] ? AB'(-acz) : AB'(acz);
    assign magxy = (magy > magx) ? magy : magx;
    assign magm  = (magz > magxy) ? magz : magxy;

    // square root step
    logic [62:0] rt;
    assign rt = rr_reg + rb_reg;

    // divide step and final quotient
    logic        dge;
    logic [16:0] qn;
    logic [14:0] qsat;
    logic [29:0] dmag;
    logic        dsgn;
    logic signed [15:0] comp;

    assign dge  = (rem_reg >= dv_reg);
    assign qn   = {q_reg[15:0], dge};
    assign qsat = (qn > 17'd32767) ? 15'h7fff : qn[14:0];
    assign comp = dsgn ? -$signed({1'b0, qsat}) : $signed({1'b0, qsat});
    always_comb
    begin
        case (cr_reg)
            2'd0:    begin dmag = mx_reg[MAG_W-1:0]; dsgn = sgn_reg[2]; end
            2'd1:    begin dmag = my_reg[MAG_W-1:0]; dsgn = sgn_reg[1]; end
            default: begin dmag = mz_reg[MAG_W-1:0]; dsgn = sgn_reg[0]; end
        endcase
    end

    // multiplier operand select
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        if (state_reg == S_CROSS)
        begin
            case (step_reg)
                5'd0:    begin op_a = MUL_W'(uy_reg); op_b = MUL_W'(vz_reg); end
                5'd1:    begin op_a = MUL_W'(uz_reg); op_b = MUL_W'(vy_reg); end
                5'd2:    begin op_a = MUL_W'(uz_reg); op_b = MUL_W'(vx_reg); end
                5'd3:    begin op_a = MUL_W'(ux_reg); op_b = MUL_W'(vz_reg); end
                5'd4:    begin op_a = MUL_W'(ux_reg); op_b = MUL_W'(vy_reg); end
                5'd5:    begin op_a = MUL_W'(uy_reg); op_b = MUL_W'(vx_reg); end
                default: begin op_a = '0; op_b = '0; end
            endcase
        end
        else if (state_reg == S_SQ)
        begin
            case (step_reg)
                5'd0:    begin op_a = {1'b0, mx_reg[MAG_W-1:0]}; op_b = {1'b0, mx_reg[MAG_W-1:0]}; end
                5'd1:    begin op_a = {1'b0, my_reg[MAG_W-1:0]}; op_b = {1'b0, my_reg[MAG_W-1:0]}; end
                5'd2:    begin op_a = {1'b0, mz_reg[MAG_W-1:0]}; op_b = {1'b0, mz_reg[MAG_W-1:0]}; end
                default: begin op_a = '0; op_b = '0; end
            endcase
        end
    end

    // main sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cr_next    = cr_reg;
        clr_next   = clr_reg;
        rv_next    = rv_reg;
        cmd_next   = cmd_reg;
        ax_next = ax_reg; ay_next = ay_reg; az_next = az_reg;
        ux_next = ux_reg; uy_next = uy_reg; uz_next = uz_reg;
        vx_next = vx_reg; vy_next = vy_reg; vz_next = vz_reg;
        tmp_next = tmp_reg;
        nx_next = nx_reg; ny_next = ny_reg; nz_next = nz_reg;
        mx_next = mx_reg; my_next = my_reg; mz_next = mz_reg; mm_next = mm_reg;
        sgn_next = sgn_reg;
        sq_next  = sq_reg;
        rs_next = rs_reg; rr_next = rr_reg; rb_next = rb_reg;
        rem_next = rem_reg; dv_next = dv_reg; q_next = q_reg;
        res_next = res_reg;
        out_next = out_reg;
        vwe    = 1'b0;
        awe    = 1'b0;
        vaddr  = adr_a;
        araddr = adr_a;
        awaddr = adr_a;
        awdata = '0;

        if (out_fire)
        begin
            rv_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                awe    = 1'b1;
                awaddr = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(MAX_VERTICES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (item_fire)
                begin
                    cmd_next = item;
                    case (item.action)
                        ACT_WRITE:
                        begin
                            vwe    = a_ok;
                            awaddr = AW'(item.vertex_index);
                        end
                        ACT_CLEAR:
                        begin
                            awe    = a_ok;
                            awaddr = AW'(item.vertex_index);
                        end
                        ACT_ADD:
                        begin
                            if (a_ok && b_ok && c_ok)
                            begin
                                state_next = S_RDA;
                            end
                        end
                        default:
                        begin
                            if (a_ok)
                            begin
                                state_next = S_NRD;
                            end
                            else
                            begin
                                res_next   = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
                                state_next = S_OUT;
                            end
                        end
                    endcase
                end
            end
            S_RDA:
            begin
                vaddr      = adr_a;
                state_next = S_RDB;
            end
            S_RDB:
            begin
                vaddr   = adr_b;
                ax_next = rdx;
                ay_next = rdy;
                az_next = rdz;
                state_next = S_RDC;
            end
            S_RDC:
            begin
                vaddr   = adr_c;
                ux_next = EDGE_BITS'(rdx) - EDGE_BITS'(ax_reg);
                uy_next = EDGE_BITS'(rdy) - EDGE_BITS'(ay_reg);
                uz_next = EDGE_BITS'(rdz) - EDGE_BITS'(az_reg);
                state_next = S_EDGE;
            end
            S_EDGE:
            begin
                vx_next = EDGE_BITS'(rdx) - EDGE_BITS'(ax_reg);
                vy_next = EDGE_BITS'(rdy) - EDGE_BITS'(ay_reg);
                vz_next = EDGE_BITS'(rdz) - EDGE_BITS'(az_reg);
                step_next  = '0;
                state_next = S_CROSS;
            end
            S_CROSS:
            begin
                // product of step k comes back at step k + 1
                step_next = step_reg + 1'b1;
                case (step_reg)
                    5'd1, 5'd3, 5'd5: tmp_next = prod[NRM_BITS-1:0];
                    5'd2:    nx_next = tmp_reg - prod[NRM_BITS-1:0];
                    5'd4:    ny_next = tmp_reg - prod[NRM_BITS-1:0];
                    5'd6:
                    begin
                        nz_next    = tmp_reg - prod[NRM_BITS-1:0];
                        cr_next    = 2'd0;
                        state_next = S_ARD;
                    end
                    default: tmp_next = tmp_reg;
                endcase
            end
            S_ARD:
            begin
                araddr     = adr_corner;
                state_next = S_AWR;
            end
            S_AWR:
            begin
                awe    = 1'b1;
                awaddr = adr_corner;
                awdata = {satx, saty, satz};
                cr_next = cr_reg + 1'b1;
                state_next = (cr_reg == 2'd2) ? S_IDLE : S_ARD;
            end
            S_NRD:
            begin
                araddr     = adr_a;
                state_next = S_NMAG;
            end
            S_NMAG:
            begin
                mx_next  = magx;
                my_next  = magy;
                mz_next  = magz;
                mm_next  = magm;
                sgn_next = {acx[AB-1], acy[AB-1], acz[AB-1]};
                if (magm == '0)
                begin
                    res_next   = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                // bring the largest magnitude into [2^29, 2^30) one bit a cycle
                if (mm_reg[AB-1:MAG_W] != '0)
                begin
                    mx_next = mx_reg >> 1;
                    my_next = my_reg >> 1;
                    mz_next = mz_reg >> 1;
                    mm_next = mm_reg >> 1;
                end
                else if (mm_reg[AB-1:MAG_W-1] == '0)
                begin
                    mx_next = mx_reg << 1;
                    my_next = my_reg << 1;
                    mz_next = mz_reg << 1;
                    mm_next = mm_reg << 1;
                end
                else
                begin
                    step_next  = '0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                step_next = step_reg + 1'b1;
                case (step_reg)
                    5'd1:    sq_next = prod;
                    5'd2:    sq_next = sq_reg + prod;
                    5'd3:
                    begin
                        rs_next    = {1'b0, sq_reg + prod};
                        rr_next    = '0;
                        rb_next    = 63'd1 << 62;
                        state_next = S_SQRT;
                    end
                    default: sq_next = sq_reg;
                endcase
            end
            S_SQRT:
            begin
                if (rs_reg >= rt)
                begin
                    rs_next = rs_reg - rt;
                    rr_next = (rr_reg >> 1) + rb_reg;
                end
                else
                begin
                    rr_next = rr_reg >> 1;
                end
                rb_next = rb_reg >> 2;
                if (rb_reg == 63'd1)
                begin
                    cr_next    = 2'd0;
                    state_next = S_DIVI;
                end
            end
            S_DIVI:
            begin
                // rr_reg now holds the length, below 2^31
                rem_next   = (48'(dmag) << 15) + 48'(rr_reg[30:1]);
                dv_next    = 48'(rr_reg[30:0]) << 16;
                q_next     = '0;
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (dge)
                begin
                    rem_next = rem_reg - dv_reg;
                end
                dv_next   = dv_reg >> 1;
                q_next    = qn;
                step_next = step_reg + 1'b1;
                if (step_reg == 5'd16)
                begin
                    case (cr_reg)
                        2'd0:    res_next.normal_x = comp;
                        2'd1:    res_next.normal_y = comp;
                        default: res_next.normal_z = comp;
                    endcase
                    res_next.zero_length = 1'b0;
                    cr_next    = cr_reg + 1'b1;
                    state_next = (cr_reg == 2'd2) ? S_OUT : S_DIVI;
                end
            end
            S_OUT:
            begin
                if (!rv_reg || !result_stall)
                begin
                    out_next   = res_reg;
                    rv_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            step_reg  <= '0;
            cr_reg    <= '0;
            clr_reg   <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            cr_reg    <= cr_next;
            clr_reg   <= clr_next;
            rv_reg    <= rv_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        ax_reg <= ax_next; ay_reg <= ay_next; az_reg <= az_next;
        ux_reg <= ux_next; uy_reg <= uy_next; uz_reg <= uz_next;
        vx_reg <= vx_next; vy_reg <= vy_next; vz_reg <= vz_next;
        tmp_reg <= tmp_next;
        nx_reg <= nx_next; ny_reg <= ny_next; nz_reg <= nz_next;
        mx_reg <= mx_next; my_reg <= my_next; mz_reg <= mz_next; mm_reg <= mm_next;
        sgn_reg <= sgn_next;
        sq_reg  <= sq_next;
        rs_reg <= rs_next; rr_reg <= rr_next; rb_reg <= rb_next;
        rem_reg <= rem_next; dv_reg <= dv_next; q_reg <= q_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    // vertex store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (vwe)
        begin
            vmem[awaddr] <= {item.coord_x, item.coord_y, item.coord_z};
        end
        vrd_reg <= vmem[vaddr];
    end

    // accumulator store, xyz side by side in one word
    always_ff @(posedge clk)
    begin
        if (awe)
        begin
            amem[awaddr] <= awdata;
        end
        ard_reg <= amem[araddr];
    end

    assign result_valid = rv_reg;
    assign result       = out_reg;

    // no result may leave while the accumulators are still being cleared
    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !result_valid)
        else $error("result during clearing pass");

    // a new result transaction is only raised from the output state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rv_reg) |-> ($past(state_reg) == S_OUT))
        else $error("result raised outside output state");

    // a zero-length result carries a zero vector
    a_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.zero_length) |->
        (result.normal_x == 16'sd0 && result.normal_y == 16'sd0 &&
         result.normal_z == 16'sd0))
        else $error("zero-length flag with nonzero components");

    // components saturate symmetrically and never reach the most negative code
    a_symmetric: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.normal_x != 16'sh8000 && result.normal_y != 16'sh8000 &&
                          result.normal_z != 16'sh8000))
        else $error("component outside symmetric range");

endmodule

@@ sim/vna_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vna_checker
// Watches both channels of the vertex normal accumulator, keeps its own copy
// of vertex store and accumulators, predicts each read result and compares.
// ----------------------------------------------------------------------------
module vna_checker
    import vna_pkg::*;
#(
    parameter int MAX_VERTICES = 256,
    parameter int ACCUM_BITS   = 48
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic    item_stall,
    input  item_t   item,
    input  logic    result_valid,
    input  logic    result_stall,
    input  result_t result,
    output int      fail_count,
    output int      pending_normals,
    output int      normals_seen,
    output int      zero_normals_seen
);

    logic signed [31:0] pos_x [MAX_VERTICES];
    logic signed [31:0] pos_y [MAX_VERTICES];
    logic signed [31:0] pos_z [MAX_VERTICES];
    logic signed [63:0] sum_x [MAX_VERTICES];
    logic signed [63:0] sum_y [MAX_VERTICES];
    logic signed [63:0] sum_z [MAX_VERTICES];
    result_t            expected_normals [$];

    assign pending_normals = expected_normals.size();

    function automatic logic signed [63:0] sat_accum(logic signed [63:0] a,
                                                    logic signed [63:0] n);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (ACCUM_BITS - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (n > 0 && a > hi - n)
            return hi;
        if (n < 0 && a < lo - n)
            return lo;
        return a + n;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] s);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s)
            b = b >> 2;
        while (b != 0)
        begin
            if (s >= r + b)
            begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] scaled_comp(logic signed [63:0] c, logic [63:0] m,
                                                logic [63:0] len);
        logic [63:0] q;
        q = ((m << 15) + (len >> 1)) / len;
        if (q > 64'd32767)
            q = 64'd32767;
        if (c < 0)
            q = -q;
        return q[15:0];
    endfunction

    function automatic result_t unit_normal(logic [7:0] idx);
        logic signed [63:0] cx, cy, cz;
        logic [63:0]        mx, my, mz, m, len;
        int                 sh;
        result_t            r;
        cx = 0;
        cy = 0;
        cz = 0;
        sh = 0;
        if (idx < MAX_VERTICES)
        begin
            cx = sum_x[idx];
            cy = sum_y[idx];
            cz = sum_z[idx];
        end
        mx = cx < 0 ? -cx : cx;
        my = cy < 0 ? -cy : cy;
        mz = cz < 0 ? -cz : cz;
        m = mx;
        if (my > m) m = my;
        if (mz > m) m = mz;
        r = '0;
        if (m == 0)
        begin
            r.zero_length = 1'b1;
            return r;
        end
        while (m >= (64'd1 << 30))
        begin
            m = m >> 1;
            sh++;
        end
        if (sh > 0)
        begin
            mx = mx >> sh; my = my >> sh; mz = mz >> sh;
        end
        else
        begin
            while (m < (64'd1 << 29))
            begin
                m = m << 1;
                sh++;
            end
            mx = mx << sh; my = my << sh; mz = mz << sh;
        end
        len = int_sqrt(mx * mx + my * my + mz * mz);
        r.normal_x = scaled_comp(cx, mx, len);
        r.normal_y = scaled_comp(cy, my, len);
        r.normal_z = scaled_comp(cz, mz, len);
        return r;
    endfunction

    task automatic add_face(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        logic signed [63:0] ux, uy, uz, vx, vy, vz, nx, ny, nz;
        logic [7:0]         k;
        if (a >= MAX_VERTICES || b >= MAX_VERTICES || c >= MAX_VERTICES)
            return;
        ux = pos_x[b] - pos_x[a];
        uy = pos_y[b] - pos_y[a];
        uz = pos_z[b] - pos_z[a];
        vx = pos_x[c] - pos_x[a];
        vy = pos_y[c] - pos_y[a];
        vz = pos_z[c] - pos_z[a];
        nx = uy * vz - uz * vy;
        ny = uz * vx - ux * vz;
        nz = ux * vy - uy * vx;
        for (int j = 0; j < 3; j++)
        begin
            k = (j == 0) ? a : (j == 1) ? b : c;
            sum_x[k] = sat_accum(sum_x[k], nx);
            sum_y[k] = sat_accum(sum_y[k], ny);
            sum_z[k] = sat_accum(sum_z[k], nz);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_VERTICES; i++)
            begin
                pos_x[i] = 0; pos_y[i] = 0; pos_z[i] = 0;
                sum_x[i] = 0; sum_y[i] = 0; sum_z[i] = 0;
            end
            expected_normals.delete();
            fail_count = 0;
            normals_seen = 0;
            zero_normals_seen = 0;
        end
        else
        begin
            // input transaction updates the shadow state
            if (item_valid && !item_stall)
            begin
                case (item.action)
                    ACT_WRITE:
                        if (item.vertex_index < MAX_VERTICES)
                        begin
                            pos_x[item.vertex_index] = item.coord_x;
                            pos_y[item.vertex_index] = item.coord_y;
                            pos_z[item.vertex_index] = item.coord_z;
                        end
                    ACT_ADD:
                        add_face(item.vertex_index, item.corner_b, item.corner_c);
                    ACT_CLEAR:
                        if (item.vertex_index < MAX_VERTICES)
                        begin
                            sum_x[item.vertex_index] = 0;
                            sum_y[item.vertex_index] = 0;
                            sum_z[item.vertex_index] = 0;
                        end
                    default:
                        expected_normals.push_back(unit_normal(item.vertex_index));
                endcase
            end
            if (result_valid && !result_stall)
            begin
                got = result;
                normals_seen++;
                if (got.zero_length)
                    zero_normals_seen++;
                if (expected_normals.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transaction %h", got);
                end
                else
                begin
                    want = expected_normals.pop_front();
                    if (got.normal_x !== want.normal_x || got.normal_y !== want.normal_y
                        || got.normal_z !== want.normal_z
                        || got.zero_length !== want.zero_length)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("normal mismatch: expected %0d %0d %0d z%0b, got %0d %0d %0d z%0b",
                                     want.normal_x, want.normal_y, want.normal_z,
                                     want.zero_length, got.normal_x, got.normal_y,
                                     got.normal_z, got.zero_length);
                    end
                end
            end
        end
    end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives mesh traffic into the vertex normal accumulator: vertex writes,
// triangles over written vertices, reads and clears, with bursty sending and
// random result stalls; the checker predicts and compares every normal.
// ----------------------------------------------------------------------------
module tb;
    import vna_pkg::*;

    localparam int  NUM_RANDOM  = 1250;
    localparam longint CYCLE_LIMIT = 2000000;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    int      fail_count;
    int      pending_normals;
    int      normals_seen;
    int      zero_normals_seen;
    longint  cycle_count = 0;
    int      sent_count;

    // vertices written so far; triangles only use these
    logic    written [256];
    int      written_list [$];

    vertex_normal_accumulator DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    vna_checker u_checker
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (item_valid),
        .item_stall        (item_stall),
        .item              (item),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .result            (result),
        .fail_count        (fail_count),
        .pending_normals   (pending_normals),
        .normals_seen      (normals_seen),
        .zero_normals_seen (zero_normals_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // watchdog: the slowest read, stalls included, is far below CYCLE_LIMIT
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver stall pattern: calm, busy and mostly stalled stretches
    initial
    begin
        int mode;
        int run;
        result_stall = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 2);
            run = $urandom_range(1, 60);
            repeat (run)
            begin
                @(negedge clk);
                case (mode)
                    0: result_stall <= 1'b0;
                    1: result_stall <= ($urandom_range(0, 3) == 0);
                    default: result_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // one transaction: hold it until the block takes it
    task automatic send(item_t it);
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sent_count++;
        if (it.action == ACT_WRITE && !written[it.vertex_index])
        begin
            written[it.vertex_index] = 1'b1;
            written_list.push_back(it.vertex_index);
        end
        @(negedge clk);
    endtask

    task automatic idle_gap(int cycles);
        item_valid <= 1'b0;
        item <= item_t'($urandom());
        repeat (cycles)
            @(negedge clk);
    endtask

    function automatic item_t make_item(logic [1:0] act, logic [7:0] a, logic [15:0] x,
                                        logic [15:0] y, logic [15:0] z,
                                        logic [7:0] b, logic [7:0] c);
        item_t it;
        it.action = act;
        it.vertex_index = a;
        it.coord_x = x;
        it.coord_y = y;
        it.coord_z = z;
        it.corner_b = b;
        it.corner_c = c;
        return it;
    endfunction

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [7:0] pick_written();
        return 8'(written_list[$urandom_range(0, written_list.size() - 1)]);
    endfunction

    // random transaction: writes, triangles over written corners, reads and clears
    function automatic item_t random_item();
        int roll;
        logic [7:0] a;
        roll = $urandom_range(0, 99);
        a = 8'($urandom());
        if (written_list.size() < 3 || roll < 25)
            return make_item(ACT_WRITE, a, rand_coord(), rand_coord(), rand_coord(),
                             8'($urandom()), 8'($urandom()));
        if (roll < 65)
            return make_item(ACT_ADD, pick_written(), 16'($urandom()), 16'($urandom()),
                             16'($urandom()), pick_written(), pick_written());
        if (roll < 90)
            return make_item(ACT_READ, ($urandom_range(0, 1) ? pick_written() : a),
                             16'($urandom()), 16'($urandom()), 16'($urandom()),
                             8'($urandom()), 8'($urandom()));
        return make_item(ACT_CLEAR, ($urandom_range(0, 1) ? pick_written() : a),
                         16'($urandom()), 16'($urandom()), 16'($urandom()),
                         8'($urandom()), 8'($urandom()));
    endfunction

    initial
    begin
        int burst;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        sent_count = 0;
        for (int i = 0; i < 256; i++)
            written[i] = 1'b0;
        repeat (3)
            @(negedge clk);
        rst_n = 1'b1;

        // directed: read before any triangle, extreme coordinates, degenerate faces
        send(make_item(ACT_READ, 8'd0, 16'h0, 16'h0, 16'h0, 8'd0, 8'd0));
        send(make_item(ACT_WRITE, 8'd0, 16'h0000, 16'h0000, 16'h0000, 8'd0, 8'd0));
        send(make_item(ACT_WRITE, 8'd1, 16'h0100, 16'h0000, 16'h0000, 8'd0, 8'd0));
        send(make_item(ACT_WRITE, 8'd2, 16'h0000, 16'h0100, 16'h0000, 8'd0, 8'd0));
        send(make_item(ACT_ADD, 8'd0, 16'h0, 16'h0, 16'h0, 8'd1, 8'd2));
        send(make_item(ACT_READ, 8'd1, 16'h0, 16'h0, 16'h0, 8'd0, 8'd0));
        // repeated corner adds the face twice; here it is degenerate
        send(make_item(ACT_ADD, 8'd1, 16'h0, 16'h0, 16'h0, 8'd1, 8'd2));
        send(make_item(ACT_READ, 8'd2, 16'h0, 16'h0, 16'h0, 8'd0, 8'd0));
        send(make_item(ACT_WRITE, 8'd253, 16'h8000, 16'h8000, 16'h8000, 8'd0, 8'd0));
        send(make_item(ACT_WRITE, 8'd254, 16'h7fff, 16'h8000, 16'h7fff, 8'd0, 8'd0));
        send(make_item(ACT_WRITE, 8'd255, 16'h8000, 16'h7fff, 16'h7fff, 8'd0, 8'd0));
        // largest faces, repeated on the same corners to build large sums
        for (int i = 0; i < 4; i++)
            send(make_item(ACT_ADD, 8'd253, 16'hffff, 16'hffff, 16'hffff,
                           8'd254, 8'd255));
        send(make_item(ACT_READ, 8'd253, 16'h0, 16'h0, 16'h0, 8'd0, 8'd0));
        send(make_item(ACT_READ, 8'd255, 16'h0, 16'h0, 16'h0, 8'd0, 8'd0));
        send(make_item(ACT_CLEAR, 8'd253, 16'h0, 16'h0, 16'h0, 8'd0, 8'd0));
        send(make_item(ACT_READ, 8'd253, 16'h0, 16'h0, 16'h0, 8'd0, 8'd0));
        send(make_item(ACT_READ, 8'd0, 16'h0, 16'h0, 16'h0, 8'd0, 8'd0));

        // hold off until every expected normal has come back
        idle_gap(1);
        while (pending_normals != 0)
            @(negedge clk);

        // random bursts with gaps; some bursts run back to back
        while (sent_count < NUM_RANDOM + 20)
        begin
            burst = $urandom_range(1, 30);
            repeat (burst)
                send(random_item());
            if ($urandom_range(0, 2) != 0)
                idle_gap($urandom_range(1, 20));
        end
        idle_gap(1);

        while (pending_normals != 0)
            @(negedge clk);
        repeat (200)
            @(negedge clk);

        $display("sent %0d transactions, checked %0d normals (%0d zero length)",
                 sent_count, normals_seen, zero_normals_seen);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
